// ===== rtl/bstio_pkg.sv =====
// Shared types and codes for the tree insert and in-order fetch engine.
package bstio_pkg;

  // Operation carried on the input tuser bit
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_FETCH  = 1'b1;

  // Result status carried on the output tuser bits
  localparam logic [1:0] STAT_INSERTED = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_VALUE    = 2'd2;
  localparam logic [1:0] STAT_DONE     = 2'd3;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_CMP,
    ST_F_DESC,
    ST_F_LEFT,
    ST_F_POP,
    ST_F_IDX,
    ST_F_VAL,
    ST_RESP
  } state_t;

endpackage

// ===== rtl/bstio_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module bstio_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [$clog2(DEPTH)-1:0]         wr_addr,
  input  logic [WIDTH-1:0]                 wr_data,
  input  logic [$clog2(DEPTH)-1:0]         rd_addr,
  output logic [WIDTH-1:0]                 rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write one entry and read one entry through a read data register
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/bst_insert_inorder_engine.sv =====
// Top level: binary search tree with insert and in-order fetch over a node RAM.
//
//  channel | ports      | tdata                    | tuser
//  --------+------------+--------------------------+---------------------------
//  input   | in_t*      | [31:0] key_value         | [0] func (0 insert, 1 fetch)
//  result  | out_t*     | [31:0] out_value         | [1:0] status
//
// Insert: the walk reads one node per level from the root (level 0) down to the
// level at which the new node is linked; the RAM read latency sets the pace.
// Rejected and first inserts skip the walk. Fetch: each node on the way down the
// left spine is pushed on the stack; a pop reads the stack RAM, then the node.
// Reset clears the node count and traversal state at once; the RAMs need no
// clearing. One beat is worked on at a time; a finished result sits in the
// output register so the next beat can be taken while the result is stalled.
module bst_insert_inorder_engine #(
  parameter int MAX_NODES   = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] key_value
  input  logic        in_tuser,   // [0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] out_value
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int AW = $clog2(MAX_NODES);
  localparam int IW = $clog2(MAX_NODES + 1);
  localparam int NW = VALUE_WIDTH + 2 * IW;
  localparam logic [IW-1:0] NULL_IDX = IW'(MAX_NODES);

  bstio_pkg::state_t state_r, state_nxt;
  logic [IW-1:0]          count_r, count_nxt;
  logic [IW-1:0]          depth_r, depth_nxt;
  logic [IW-1:0]          cursor_r, cursor_nxt;
  logic                   started_r, started_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [VALUE_WIDTH-1:0] key_r, key_nxt;
  logic [AW-1:0]          cur_r, cur_nxt;
  logic [31:0]            res_value_r, res_value_nxt;
  logic [1:0]             res_status_r, res_status_nxt;
  logic [31:0]            out_value_r, out_value_nxt;
  logic [1:0]             out_status_r, out_status_nxt;

  logic                   node_we;
  logic [AW-1:0]          node_waddr;
  logic [NW-1:0]          node_wdata;
  logic [AW-1:0]          node_raddr;
  logic [NW-1:0]          node_rdata;
  logic                   stk_we;
  logic [AW-1:0]          stk_waddr;
  logic [AW-1:0]          stk_wdata;
  logic [AW-1:0]          stk_raddr;
  logic [AW-1:0]          stk_rdata;

  logic [VALUE_WIDTH-1:0] nd_value;
  logic [IW-1:0]          nd_left;
  logic [IW-1:0]          nd_right;
  logic                   key_ge;
  logic                   in_fire;
  logic                   out_free;

  // Node word: value, left link, right link
  bstio_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_node_ram (
    .clk     (clk),
    .wr_en   (node_we),
    .wr_addr (node_waddr),
    .wr_data (node_wdata),
    .rd_addr (node_raddr),
    .rd_data (node_rdata)
  );

  // Traversal stack of node indices
  bstio_ram #(.WIDTH(AW), .DEPTH(MAX_NODES)) u_stack_ram (
    .clk     (clk),
    .wr_en   (stk_we),
    .wr_addr (stk_waddr),
    .wr_data (stk_wdata),
    .rd_addr (stk_raddr),
    .rd_data (stk_rdata)
  );

  assign nd_value = node_rdata[NW-1 -: VALUE_WIDTH];
  assign nd_left  = node_rdata[2*IW-1 -: IW];
  assign nd_right = node_rdata[IW-1:0];
  assign key_ge   = $signed(key_r) >= $signed(nd_value);

  assign in_tready  = (state_r == bstio_pkg::ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_status_r;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bstio_pkg::ST_IDLE;
      count_r     <= '0;
      depth_r     <= '0;
      cursor_r    <= NULL_IDX;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      depth_r     <= depth_nxt;
      cursor_r    <= cursor_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    cur_r        <= cur_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  // Sequencer: insert walk, fetch descent and pop, result hand-off
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    depth_nxt      = depth_r;
    cursor_nxt     = cursor_r;
    started_nxt    = started_r;
    key_nxt        = key_r;
    cur_nxt        = cur_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    node_we        = 1'b0;
    node_waddr     = count_r[AW-1:0];
    node_wdata     = {key_r, NULL_IDX, NULL_IDX};
    node_raddr     = '0;
    stk_we         = 1'b0;
    stk_waddr      = depth_r[AW-1:0];
    stk_wdata      = cursor_r[AW-1:0];
    stk_raddr      = '0;

    case (state_r)
      bstio_pkg::ST_IDLE: begin
        if (in_fire) begin
          key_nxt       = VALUE_WIDTH'($signed(in_tdata));
          res_value_nxt = '0;
          if (in_tuser == bstio_pkg::FUNC_FETCH) begin
            // start the traversal at the root on the first fetch after reset or an insert
            if (!started_r) begin
              cursor_nxt  = (count_r != '0) ? '0 : NULL_IDX;
              depth_nxt   = '0;
              started_nxt = 1'b1;
            end
            state_nxt = bstio_pkg::ST_F_DESC;
          end else if (count_r == NULL_IDX) begin
            res_status_nxt = bstio_pkg::STAT_FULL;
            state_nxt      = bstio_pkg::ST_RESP;
          end else begin
            // write the new leaf, then walk from the root to link it
            node_we     = 1'b1;
            node_wdata  = {VALUE_WIDTH'($signed(in_tdata)), NULL_IDX, NULL_IDX};
            node_raddr  = '0;
            cur_nxt     = '0;
            started_nxt = 1'b0;
            depth_nxt   = '0;
            cursor_nxt  = NULL_IDX;
            if (count_r == '0) begin
              count_nxt      = count_r + IW'(1);
              res_status_nxt = bstio_pkg::STAT_INSERTED;
              state_nxt      = bstio_pkg::ST_RESP;
            end else begin
              state_nxt = bstio_pkg::ST_INS_CMP;
            end
          end
        end
      end

      bstio_pkg::ST_INS_CMP: begin
        // compare against the node just read; link or descend
        if (key_ge) begin
          if (nd_right == NULL_IDX) begin
            node_we        = 1'b1;
            node_waddr     = cur_r;
            node_wdata     = {nd_value, nd_left, count_r};
            count_nxt      = count_r + IW'(1);
            res_status_nxt = bstio_pkg::STAT_INSERTED;
            state_nxt      = bstio_pkg::ST_RESP;
          end else begin
            cur_nxt    = nd_right[AW-1:0];
            node_raddr = nd_right[AW-1:0];
          end
        end else begin
          if (nd_left == NULL_IDX) begin
            node_we        = 1'b1;
            node_waddr     = cur_r;
            node_wdata     = {nd_value, count_r, nd_right};
            count_nxt      = count_r + IW'(1);
            res_status_nxt = bstio_pkg::STAT_INSERTED;
            state_nxt      = bstio_pkg::ST_RESP;
          end else begin
            cur_nxt    = nd_left[AW-1:0];
            node_raddr = nd_left[AW-1:0];
          end
        end
      end

      bstio_pkg::ST_F_DESC: begin
        // push the cursor and fetch its left link
        if (cursor_r != NULL_IDX && depth_r < NULL_IDX) begin
          stk_we     = 1'b1;
          stk_waddr  = depth_r[AW-1:0];
          stk_wdata  = cursor_r[AW-1:0];
          depth_nxt  = depth_r + IW'(1);
          node_raddr = cursor_r[AW-1:0];
          state_nxt  = bstio_pkg::ST_F_LEFT;
        end else begin
          state_nxt = bstio_pkg::ST_F_POP;
        end
      end

      bstio_pkg::ST_F_LEFT: begin
        // follow the left spine one node a cycle
        cursor_nxt = nd_left;
        if (nd_left != NULL_IDX && depth_r < NULL_IDX) begin
          stk_we     = 1'b1;
          stk_waddr  = depth_r[AW-1:0];
          stk_wdata  = nd_left[AW-1:0];
          depth_nxt  = depth_r + IW'(1);
          node_raddr = nd_left[AW-1:0];
        end else begin
          state_nxt = bstio_pkg::ST_F_POP;
        end
      end

      bstio_pkg::ST_F_POP: begin
        if (depth_r == '0) begin
          cursor_nxt     = NULL_IDX;
          res_status_nxt = bstio_pkg::STAT_DONE;
          state_nxt      = bstio_pkg::ST_RESP;
        end else begin
          depth_nxt = depth_r - IW'(1);
          stk_raddr = depth_nxt[AW-1:0];
          state_nxt = bstio_pkg::ST_F_IDX;
        end
      end

      bstio_pkg::ST_F_IDX: begin
        node_raddr = stk_rdata;
        state_nxt  = bstio_pkg::ST_F_VAL;
      end

      bstio_pkg::ST_F_VAL: begin
        // give the value and move to the right subtree
        res_value_nxt  = 32'(nd_value);
        res_status_nxt = bstio_pkg::STAT_VALUE;
        cursor_nxt     = nd_right;
        state_nxt      = bstio_pkg::ST_RESP;
      end

      bstio_pkg::ST_RESP: begin
        // hand the result to the output register once it is free
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = res_value_r;
          out_status_nxt = res_status_r;
          state_nxt      = bstio_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = bstio_pkg::ST_IDLE;
      end
    endcase
  end

  // Node count stays within the node memory
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NULL_IDX)
    else $error("node count beyond capacity");

  // The stack never holds more entries than there are nodes
  a_depth_le_count: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= count_r)
    else $error("stack deeper than tree");

  // An insert into a full tree leaves the count alone
  a_full_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser == bstio_pkg::FUNC_INSERT && count_r == NULL_IDX)
      |=> $stable(count_r))
    else $error("full tree insert changed count");

  // A new result is loaded only from the hand-off state
  a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != bstio_pkg::ST_RESP && !(out_valid_r && !out_tready)) |=> !out_valid_r)
    else $error("result appeared outside hand-off");

endmodule
